/* sv/bqf_pkg.sv */
`timescale 1ns / 1ps
// bqf_pkg: shared types, constants and helper functions of the biquad filter core
// used by the controller, the datapath and the top level; no dependencies

package bqf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int GAIN_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;
    localparam int MUL_A_W  = 18;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 40;
    localparam int FRAC_SHIFT = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6554;

    localparam logic [CFG_IDX_W-1:0] CFG_FF_COEF_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FF_COEF_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FF_COEF_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_COEF_1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_COEF_2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_B0,
        ST_MUL_B1,
        ST_MUL_B2,
        ST_MUL_A1,
        ST_MUL_A2,
        ST_ACC_LAST,
        ST_SAT_Y,
        ST_MUL_GAIN,
        ST_OUT
    } bqf_state_t;

    typedef enum logic [2:0] {
        SEL_B0_X,
        SEL_B1_X1,
        SEL_B2_X2,
        SEL_A1_Y1,
        SEL_A2_Y2,
        SEL_GAIN_Y
    } bqf_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        bqf_sel_t sel;
        logic     acc_en;
        logic     acc_sub;
        logic     hist_en;
        logic     out_en;
    } bqf_cmd_t;

    typedef struct packed {
        logic out_busy;
    } bqf_status_t;

    // round half up and drop 16 fraction bits, then clamp to 16 bits signed
    function automatic logic signed [SAMPLE_W-1:0] round_sat_acc(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W-FRAC_SHIFT-1:0] s;
        logic signed [SAMPLE_W-1:0] res;
        r = v + ACC_W'(32768);
        s = r[ACC_W-1:FRAC_SHIFT];
        if (s > (ACC_W-FRAC_SHIFT)'(32767))
            res = 16'sh7fff;
        else if (s < -(ACC_W-FRAC_SHIFT)'(32768))
            res = -16'sh8000;
        else
            res = s[SAMPLE_W-1:0];
        return res;
    endfunction

endpackage

/* sv/bqf_if.sv */
`timescale 1ns / 1ps
// bqf_in_if, bqf_out_if: valid/ready sample channels of the biquad filter core
// payload widths from bqf_pkg

interface bqf_in_if;
    import bqf_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_W-1:0]  sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface bqf_out_if;
    import bqf_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_W-1:0]  sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

/* sv/bqf_ctrl.sv */
`timescale 1ns / 1ps
// bqf_ctrl: sequencer of the biquad filter, one state per datapath step
// depends on bqf_pkg for the state, command and status types

module bqf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bqf_pkg::bqf_status_t status,
    output bqf_pkg::bqf_cmd_t    cmd
);
    import bqf_pkg::*;

    bqf_state_t state_reg;
    bqf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.mul_en  = 1'b0;
        cmd.sel     = SEL_B0_X;
        cmd.acc_en  = 1'b0;
        cmd.acc_sub = 1'b0;
        cmd.hist_en = 1'b0;
        cmd.out_en  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL_B0;
                end
            end
            ST_MUL_B0:
            begin
                cmd.mul_en = 1'b1;
                cmd.sel    = SEL_B0_X;
                state_next = ST_MUL_B1;
            end
            ST_MUL_B1:
            begin
                cmd.mul_en = 1'b1;
                cmd.sel    = SEL_B1_X1;
                cmd.acc_en = 1'b1;
                state_next = ST_MUL_B2;
            end
            ST_MUL_B2:
            begin
                cmd.mul_en = 1'b1;
                cmd.sel    = SEL_B2_X2;
                cmd.acc_en = 1'b1;
                state_next = ST_MUL_A1;
            end
            ST_MUL_A1:
            begin
                cmd.mul_en = 1'b1;
                cmd.sel    = SEL_A1_Y1;
                cmd.acc_en = 1'b1;
                state_next = ST_MUL_A2;
            end
            ST_MUL_A2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.sel     = SEL_A2_Y2;
                cmd.acc_en  = 1'b1;
                cmd.acc_sub = 1'b1;
                state_next  = ST_ACC_LAST;
            end
            ST_ACC_LAST:
            begin
                cmd.acc_en  = 1'b1;
                cmd.acc_sub = 1'b1;
                state_next  = ST_SAT_Y;
            end
            ST_SAT_Y:
            begin
                cmd.hist_en = 1'b1;
                state_next  = ST_MUL_GAIN;
            end
            ST_MUL_GAIN:
            begin
                cmd.mul_en = 1'b1;
                cmd.sel    = SEL_GAIN_Y;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold here while the previous item still waits downstream
                if (!status.out_busy)
                begin
                    cmd.out_en = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/bqf_datapath.sv */
`timescale 1ns / 1ps
// bqf_datapath: coefficient registers, histories, shared multiplier,
// accumulator and output register; depends on bqf_pkg and bqf_if

module bqf_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bqf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bqf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic signed [bqf_pkg::SAMPLE_W-1:0] sample_in,
    input  bqf_pkg::bqf_cmd_t                 cmd,
    output bqf_pkg::bqf_status_t              status,
    bqf_out_if.source                         dout
);
    import bqf_pkg::*;

    logic signed [COEF_W-1:0]   ff0_reg;
    logic signed [COEF_W-1:0]   ff1_reg;
    logic signed [COEF_W-1:0]   ff2_reg;
    logic signed [COEF_W-1:0]   fb1_reg;
    logic signed [COEF_W-1:0]   fb2_reg;
    logic [GAIN_W-1:0]          gain_reg;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] x1_reg;
    logic signed [SAMPLE_W-1:0] x2_reg;
    logic signed [SAMPLE_W-1:0] y1_reg;
    logic signed [SAMPLE_W-1:0] y2_reg;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic signed [SAMPLE_W-1:0] out_sat;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff0_reg  <= '0;
            ff1_reg  <= '0;
            ff2_reg  <= '0;
            fb1_reg  <= '0;
            fb2_reg  <= '0;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FF_COEF_0:   ff0_reg  <= cfg_data;
                CFG_FF_COEF_1:   ff1_reg  <= cfg_data;
                CFG_FF_COEF_2:   ff2_reg  <= cfg_data;
                CFG_FB_COEF_1:   fb1_reg  <= cfg_data;
                CFG_FB_COEF_2:   fb2_reg  <= cfg_data;
                CFG_OUTPUT_GAIN: gain_reg <= cfg_data[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        case (cmd.sel)
            SEL_B0_X:
            begin
                mul_a = ff0_reg;
                mul_b = {x_reg[SAMPLE_W-1], x_reg};
            end
            SEL_B1_X1:
            begin
                mul_a = ff1_reg;
                mul_b = {x1_reg[SAMPLE_W-1], x1_reg};
            end
            SEL_B2_X2:
            begin
                mul_a = ff2_reg;
                mul_b = {x2_reg[SAMPLE_W-1], x2_reg};
            end
            SEL_A1_Y1:
            begin
                mul_a = fb1_reg;
                mul_b = {y1_reg[SAMPLE_W-1], y1_reg};
            end
            SEL_A2_Y2:
            begin
                mul_a = fb2_reg;
                mul_b = {y2_reg[SAMPLE_W-1], y2_reg};
            end
            SEL_GAIN_Y:
            begin
                mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, gain_reg};
                mul_b = {y1_reg[SAMPLE_W-1], y1_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_next  = cmd.acc_sub ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
    assign y_sat     = round_sat_acc(acc_reg);
    assign out_sat   = round_sat_acc(prod_ext);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= sample_in;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.load)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.out_en)
        begin
            out_data_reg <= out_sat;
        end
    end

    // filter histories
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (cmd.hist_en)
        begin
            x2_reg <= x1_reg;
            x1_reg <= x_reg;
            y2_reg <= y1_reg;
            y1_reg <= y_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_busy = out_valid_reg && !dout.ready;
    assign dout.valid      = out_valid_reg;
    assign dout.sample_out = out_data_reg;

endmodule

/* sv/biquad_iir_lowpass_filter_core.sv */
`timescale 1ns / 1ps
// biquad_iir_lowpass_filter_core: direct form I biquad with output gain
// the single shared multiplier does six products in sequence, followed by round and
// saturate steps; a new sample is accepted only after the previous result is loaded
// into the output register, where it waits until it is taken
// reset: async active low, histories cleared, coefficients 0, gain 6554
// depends on bqf_pkg, bqf_if, bqf_ctrl, bqf_datapath

module biquad_iir_lowpass_filter_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bqf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bqf_pkg::CFG_DATA_W-1:0]  cfg_data,
    bqf_in_if.sink                          din,
    bqf_out_if.source                       dout
);
    import bqf_pkg::*;

    bqf_cmd_t    cmd;
    bqf_status_t status;
    logic        in_ready;

    assign din.ready = in_ready;

    bqf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bqf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_in (din.sample_in),
        .cmd       (cmd),
        .status    (status),
        .dout      (dout)
    );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for biquad_iir_lowpass_filter_core, bit-exact filter
// prediction in a scoreboard class, random stall bursts on both channels
// depends on bqf_pkg, bqf_if and the core rtl

module testbench;
    import bqf_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int RANDOM_PHASES = 6;
    localparam int MAX_REPORTS = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_0 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_1 = 3'd7;

    typedef logic [CFG_DATA_W-1:0] reg_bank_t [8];

    typedef enum int {
        STYLE_LOWPASS,
        STYLE_FULL,
        STYLE_SMALL,
        STYLE_EDGES
    } setting_style_t;

    class biquad_scoreboard;
        logic signed [COEF_W-1:0]   ff0 = '0;
        logic signed [COEF_W-1:0]   ff1 = '0;
        logic signed [COEF_W-1:0]   ff2 = '0;
        logic signed [COEF_W-1:0]   fb1 = '0;
        logic signed [COEF_W-1:0]   fb2 = '0;
        logic [GAIN_W-1:0]          gain = GAIN_RESET;
        logic signed [SAMPLE_W-1:0] x1 = '0;
        logic signed [SAMPLE_W-1:0] x2 = '0;
        logic signed [SAMPLE_W-1:0] y1 = '0;
        logic signed [SAMPLE_W-1:0] y2 = '0;
        logic signed [SAMPLE_W-1:0] expected_out [$];
        int mismatches = 0;
        int checked = 0;

        function logic signed [SAMPLE_W-1:0] round_sat(longint v);
            longint s;
            s = (v + 64'sd32768) >>> FRAC_SHIFT;
            if (s > 64'sd32767)
                return 16'sh7fff;
            if (s < -64'sd32768)
                return 16'sh8000;
            return s[SAMPLE_W-1:0];
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_FF_COEF_0:   ff0 = data[COEF_W-1:0];
                CFG_FF_COEF_1:   ff1 = data[COEF_W-1:0];
                CFG_FF_COEF_2:   ff2 = data[COEF_W-1:0];
                CFG_FB_COEF_1:   fb1 = data[COEF_W-1:0];
                CFG_FB_COEF_2:   fb2 = data[COEF_W-1:0];
                CFG_OUTPUT_GAIN: gain = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] x);
            longint acc;
            logic signed [SAMPLE_W-1:0] y;
            acc = longint'(ff0) * longint'(x) + longint'(ff1) * longint'(x1)
                + longint'(ff2) * longint'(x2) - longint'(fb1) * longint'(y1)
                - longint'(fb2) * longint'(y2);
            y = round_sat(acc);
            x2 = x1;
            x1 = x;
            y2 = y1;
            y1 = y;
            expected_out.push_back(round_sat(longint'(y) * longint'(gain)));
        endfunction

        function void check_sample(logic signed [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            checked++;
            if (expected_out.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("output sample %0d arrived with none expected", got);
                return;
            end
            want = expected_out.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("sample_out mismatch at output %0d: expected %0d, got %0d",
                             checked, want, got);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bqf_in_if  din_if ();
    bqf_out_if dout_if ();

    biquad_iir_lowpass_filter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .din       (din_if),
        .dout      (dout_if)
    );

    biquad_scoreboard chk = new;

    bit no_idle = 1'b0;
    bit hold_request = 1'b0;
    int long_holds = 0;
    int samples_sent = 0;
    int settings_used = 0;
    int quiet_cycles = 0;
    int square_count = 0;
    logic signed [SAMPLE_W-1:0] square_amp = 16'sd8000;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // sink side: random stall bursts plus long hold-offs on request
    initial
    begin : sink_side
        int stall_left;
        stall_left = 0;
        dout_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
                long_holds++;
            end
            else if (stall_left == 0 && !no_idle && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 9);
            if (stall_left > 0)
            begin
                stall_left--;
                dout_if.ready <= 1'b0;
            end
            else
                dout_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dout_if.valid && dout_if.ready)
                chk.check_sample(dout_if.sample_out);
            if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        int gap;
        @(negedge clk);
        din_if.valid <= 1'b1;
        din_if.sample_in <= x;
        do
            @(posedge clk);
        while (!din_if.ready);
        chk.note_sample(x);
        samples_sent++;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            @(negedge clk);
            din_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic close_and_drain;
        @(negedge clk);
        din_if.valid <= 1'b0;
        while (chk.expected_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_filter(input reg_bank_t bank, input logic [CFG_IDX_W-1:0] last_index);
        for (int i = 0; i <= int'(last_index); i++)
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= bank[i];
            @(posedge clk);
            chk.set_register(CFG_IDX_W'(i), bank[i]);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] edge_coef();
        case ($urandom_range(0, 3))
            0: return 18'h1ffff;
            1: return 18'h20000;
            2: return 18'h3ffff;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic reg_bank_t pick_setting(setting_style_t style);
        reg_bank_t bank;
        int fb2_val;
        int ff_val;
        bank = '{default: '0};
        fb2_val = $urandom_range(16384, 58000);
        ff_val = $urandom_range(200, 4000);
        case (style)
            STYLE_LOWPASS:
            begin
                bank[CFG_FF_COEF_0] = CFG_DATA_W'(ff_val);
                bank[CFG_FF_COEF_1] = CFG_DATA_W'(2 * ff_val);
                bank[CFG_FF_COEF_2] = CFG_DATA_W'(ff_val);
                bank[CFG_FB_COEF_1] = CFG_DATA_W'(-int'($urandom_range(40000, 63000 + fb2_val)));
                bank[CFG_FB_COEF_2] = CFG_DATA_W'(fb2_val);
            end
            STYLE_FULL:
            begin
                for (int i = 0; i <= int'(CFG_FB_COEF_2); i++)
                    bank[i] = CFG_DATA_W'($urandom);
            end
            STYLE_SMALL:
            begin
                for (int i = 0; i <= int'(CFG_FB_COEF_2); i++)
                    bank[i] = CFG_DATA_W'(int'($urandom_range(0, 16384)) - 8192);
            end
            default:
            begin
                for (int i = 0; i <= int'(CFG_FB_COEF_2); i++)
                    bank[i] = edge_coef();
            end
        endcase
        bank[CFG_OUTPUT_GAIN] = CFG_DATA_W'($urandom);
        return bank;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        square_count++;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return SAMPLE_W'($urandom);
            4, 5: return SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
            6:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
            default: return square_count[4] ? square_amp : -square_amp;
        endcase
    endfunction

    initial
    begin : stimulus
        reg_bank_t bank;
        logic signed [SAMPLE_W-1:0] startup_x [8];
        logic signed [SAMPLE_W-1:0] extreme_x [10];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        din_if.valid = 1'b0;
        din_if.sample_in = '0;
        startup_x = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0000,
                      16'sh0001, 16'shffff, 16'sd12345, 16'sh8000};
        extreme_x = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                      16'sh8000, 16'sh0000, 16'sh0000, 16'sh0001, 16'shffff};
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // start-up with zero histories, gain left at its reset value
        bank = '{default: '0};
        bank[CFG_FF_COEF_0] = 18'h10000;
        bank[CFG_FF_COEF_1] = CFG_DATA_W'(-32768);
        bank[CFG_FF_COEF_2] = 18'h04000;
        bank[CFG_FB_COEF_1] = 18'h02000;
        bank[CFG_FB_COEF_2] = CFG_DATA_W'(-4096);
        program_filter(bank, CFG_FB_COEF_2);
        foreach (startup_x[i])
            send_sample(startup_x[i]);
        close_and_drain();

        // extreme coefficients, wide gain value, writes to unused indexes
        bank[CFG_FF_COEF_0] = 18'h1ffff;
        bank[CFG_FF_COEF_1] = 18'h20000;
        bank[CFG_FF_COEF_2] = 18'h1ffff;
        bank[CFG_FB_COEF_1] = 18'h20000;
        bank[CFG_FB_COEF_2] = 18'h1ffff;
        bank[CFG_OUTPUT_GAIN] = 18'h3ffff;
        bank[CFG_SPARE_0] = CFG_DATA_W'($urandom);
        bank[CFG_SPARE_1] = CFG_DATA_W'($urandom);
        program_filter(bank, CFG_SPARE_1);
        foreach (extreme_x[i])
            send_sample(extreme_x[i]);
        close_and_drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    bank = pick_setting(STYLE_LOWPASS);
                    bank[CFG_OUTPUT_GAIN] = {2'($urandom), 16'hffff};
                end
                1: bank = pick_setting(STYLE_FULL);
                2:
                begin
                    bank = pick_setting(STYLE_LOWPASS);
                    bank[CFG_OUTPUT_GAIN] = '0;
                end
                3: bank = pick_setting(STYLE_SMALL);
                4: bank = pick_setting(STYLE_EDGES);
                default: bank = pick_setting(STYLE_LOWPASS);
            endcase
            program_filter(bank, CFG_OUTPUT_GAIN);
            square_amp = SAMPLE_W'($urandom_range(1000, 32000));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 40 == 0)
                    no_idle = (p == RANDOM_PHASES - 1) || ($urandom_range(0, 3) == 0);
                if ((p == 1 || p == 3) && n == 100)
                    hold_request = 1'b1;
                send_sample(pick_sample());
            end
            close_and_drain();
        end

        $display("%0d input items sent, %0d output items checked, %0d filter settings",
                 samples_sent, chk.checked, settings_used);
        $display("%0d long output hold-offs, %0d mismatches, %0d results outstanding",
                 long_holds, chk.mismatches, chk.expected_out.size());
        if (chk.mismatches == 0 && chk.expected_out.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
